### hw/rtl/cfd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame deframer.
package cfd_pkg;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CIDX_W = 8;

  // CRC-16 constants (MSB first, no reflection, no final xor).
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'h55;
  localparam logic [BYTE_W-1:0] MAX_PAY_RST    = 8'hFF;
  localparam logic [CRC_W-1:0]  CRC_START_RST  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_HDR_FIRST  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_HDR_SECOND = 8'd1;
  localparam logic [CIDX_W-1:0] REG_MAX_PAY    = 8'd2;
  localparam logic [CIDX_W-1:0] REG_CRC_START  = 8'd3;

  // Frame status codes.
  localparam logic [STAT_W-1:0] ST_GOOD     = 2'd0;
  localparam logic [STAT_W-1:0] ST_CRC_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LEN_OVER = 2'd2;

  // Depth of the queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PW    = $clog2(Q_DEPTH);

  // Classified byte kinds passed from front to back.
  typedef enum logic [2:0] {
    OP_HDR  = 3'd0,
    OP_LEN  = 3'd1,
    OP_OVER = 3'd2,
    OP_CMD  = 3'd3,
    OP_PAY  = 3'd4,
    OP_CRCH = 3'd5,
    OP_CRCL = 3'd6
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] data;
  } op_t;

  // One byte through the CRC register, one bit per step.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/cfd_front.sv
// Front part: tracks the frame phase and classifies each received byte.
module cfd_front
  import cfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic [BYTE_W-1:0] hdr_first,
  input  logic [BYTE_W-1:0] hdr_second,
  input  logic [BYTE_W-1:0] max_pay,
  input  logic              q_full,
  output logic              q_push,
  output op_t               q_op
);

  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_LEN   = 7'b0000100,
    PH_CMD   = 7'b0001000,
    PH_PAY   = 7'b0010000,
    PH_CRCH  = 7'b0100000,
    PH_CRCL  = 7'b1000000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic              take;

  assign take = in_push && !q_full;

  // Phase transitions and classification of the accepted word.
  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    q_push      = 1'b0;
    q_op.kind   = OP_PAY;
    q_op.data   = in_rx_byte;
    if (take) begin
      case (phase_r)
        PH_HUNT2: begin
          if (in_rx_byte == hdr_second) begin
            q_push    = 1'b1;
            q_op.kind = OP_HDR;
            phase_nxt = PH_LEN;
          end else if (in_rx_byte != hdr_first) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_LEN: begin
          len_nxt = in_rx_byte;
          q_push  = 1'b1;
          if (in_rx_byte > max_pay) begin
            q_op.kind = OP_OVER;
            phase_nxt = PH_HUNT1;
          end else begin
            q_op.kind = OP_LEN;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          q_push    = 1'b1;
          q_op.kind = OP_CMD;
          left_nxt  = len_r;
          phase_nxt = (len_r != '0) ? PH_PAY : PH_CRCH;
        end
        PH_PAY: begin
          q_push    = 1'b1;
          q_op.kind = OP_PAY;
          left_nxt  = left_r - 1'b1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_CRCH;
          end
        end
        PH_CRCH: begin
          q_push    = 1'b1;
          q_op.kind = OP_CRCH;
          phase_nxt = PH_CRCL;
        end
        PH_CRCL: begin
          q_push    = 1'b1;
          q_op.kind = OP_CRCL;
          phase_nxt = PH_HUNT1;
        end
        default: begin
          phase_nxt = (in_rx_byte == hdr_first) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      len_r   <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

### hw/rtl/cfd_queue.sv
// Short queue of classified words between the front and back parts.
module cfd_queue
  import cfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic full,
  output logic empty
);

  op_t             mem_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PW:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == Q_DEPTH[Q_PW:0]);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/cfd_back.sv
// Back part: runs the CRC, keeps frame fields and builds result words.
module cfd_back
  import cfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] hdr_first,
  input  logic [BYTE_W-1:0] hdr_second,
  input  logic [CRC_W-1:0]  crc_start,
  input  logic              q_empty,
  input  op_t               q_head,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_frame_end,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic [BYTE_W-1:0] out_command_id,
  output logic [BYTE_W-1:0] out_payload_length,
  output logic [STAT_W-1:0] out_status,
  output logic [CRC_W-1:0]  out_received_crc,
  output logic [CRC_W-1:0]  out_computed_crc
);

  logic [CRC_W-1:0]  seed1_r, seed_r;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;
  logic [CRC_W-1:0]  crc_upd;
  logic [CRC_W-1:0]  rx_crc;
  logic              slot_free;
  logic              emit;

  logic              ov_r, ov_nxt;
  logic              fe_r, fe_nxt;
  logic [BYTE_W-1:0] pb_r, pb_nxt;
  logic [BYTE_W-1:0] ci_r, ci_nxt;
  logic [BYTE_W-1:0] pl_r, pl_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [CRC_W-1:0]  rc_r, rc_nxt;
  logic [CRC_W-1:0]  cc_r, cc_nxt;

  // Per-frame CRC seed over both header bytes, in two registered steps.
  always_ff @(posedge clk) begin
    seed1_r <= crc_byte(crc_start, hdr_first);
    seed_r  <= crc_byte(seed1_r, hdr_second);
  end

  assign slot_free = !ov_r || out_pop;
  assign q_pop     = slot_free && !q_empty;
  assign crc_upd   = crc_byte(crc_r, q_head.data);
  assign rx_crc    = {hi_r, q_head.data};

  // Execute one classified word.
  always_comb begin
    crc_nxt = crc_r;
    len_nxt = len_r;
    cmd_nxt = cmd_r;
    hi_nxt  = hi_r;
    emit    = 1'b0;
    fe_nxt  = 1'b0;
    pb_nxt  = '0;
    ci_nxt  = cmd_r;
    pl_nxt  = len_r;
    st_nxt  = ST_GOOD;
    rc_nxt  = '0;
    cc_nxt  = '0;
    if (q_pop) begin
      case (q_head.kind)
        OP_HDR: begin
          crc_nxt = seed_r;
        end
        OP_LEN: begin
          len_nxt = q_head.data;
          cmd_nxt = '0;
          crc_nxt = crc_upd;
        end
        OP_OVER: begin
          len_nxt = q_head.data;
          cmd_nxt = '0;
          emit    = 1'b1;
          fe_nxt  = 1'b1;
          ci_nxt  = '0;
          pl_nxt  = q_head.data;
          st_nxt  = ST_LEN_OVER;
        end
        OP_CMD: begin
          cmd_nxt = q_head.data;
          crc_nxt = crc_upd;
        end
        OP_PAY: begin
          crc_nxt = crc_upd;
          emit    = 1'b1;
          pb_nxt  = q_head.data;
        end
        OP_CRCH: begin
          hi_nxt = q_head.data;
        end
        OP_CRCL: begin
          emit   = 1'b1;
          fe_nxt = 1'b1;
          st_nxt = (rx_crc == crc_r) ? ST_GOOD : ST_CRC_BAD;
          rc_nxt = rx_crc;
          cc_nxt = crc_r;
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  // Output register valid flag.
  always_comb begin
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_START_RST;
      len_r <= '0;
      cmd_r <= '0;
      hi_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      len_r <= len_nxt;
      cmd_r <= cmd_nxt;
      hi_r  <= hi_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      fe_r <= fe_nxt;
      pb_r <= pb_nxt;
      ci_r <= ci_nxt;
      pl_r <= pl_nxt;
      st_r <= st_nxt;
      rc_r <= rc_nxt;
      cc_r <= cc_nxt;
    end
  end

  assign out_empty          = !ov_r;
  assign out_frame_end      = fe_r;
  assign out_payload_byte   = pb_r;
  assign out_command_id     = ci_r;
  assign out_payload_length = pl_r;
  assign out_status         = st_r;
  assign out_received_crc   = rc_r;
  assign out_computed_crc   = cc_r;

endmodule

### hw/rtl/crc16_frame_deframer.sv
// Top level of the CRC-16 frame deframer: configuration registers and part wiring.
// The deframer takes one received byte per clock and hunts for the two-byte header,
// then reads length, command, payload and a big-endian CRC-16 (polynomial 0x1021,
// MSB first) computed from crc_start over header through payload. Every payload
// byte comes out as a word with frame_end low; at frame end a status word reports
// good, CRC mismatch or length over limit, and an over-limit length ends the frame
// at once. A byte is taken every cycle as long as full is low; a word reaches the
// result side through the four-entry classification queue and then through the CRC
// update into the output register, which holds its word while the output side stalls.
// full rises only when the output side has stalled long enough to fill that queue.
// Configuration writes are always ready and should be made while no frame is in
// flight; the CRC seed is registered from crc_start and the header bytes.
module crc16_frame_deframer
  import cfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_frame_end,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic [BYTE_W-1:0] out_command_id,
  output logic [BYTE_W-1:0] out_payload_length,
  output logic [STAT_W-1:0] out_status,
  output logic [CRC_W-1:0]  out_received_crc,
  output logic [CRC_W-1:0]  out_computed_crc,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]  cfg_data
);

  logic [BYTE_W-1:0] hdr_first_r, hdr_second_r, max_pay_r;
  logic [CRC_W-1:0]  crc_start_r;
  logic              q_push, q_pop, q_full, q_empty;
  op_t               q_in, q_head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
      max_pay_r    <= MAX_PAY_RST;
      crc_start_r  <= CRC_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HDR_FIRST:  hdr_first_r  <= cfg_data[BYTE_W-1:0];
        REG_HDR_SECOND: hdr_second_r <= cfg_data[BYTE_W-1:0];
        REG_MAX_PAY:    max_pay_r    <= cfg_data[BYTE_W-1:0];
        REG_CRC_START:  crc_start_r  <= cfg_data;
        default: begin
          crc_start_r <= crc_start_r;
        end
      endcase
    end
  end

  cfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .hdr_first  (hdr_first_r),
    .hdr_second (hdr_second_r),
    .max_pay    (max_pay_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (q_in)
  );

  cfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in),
    .pop     (q_pop),
    .head_op (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  cfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .hdr_first          (hdr_first_r),
    .hdr_second         (hdr_second_r),
    .crc_start          (crc_start_r),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_frame_end      (out_frame_end),
    .out_payload_byte   (out_payload_byte),
    .out_command_id     (out_command_id),
    .out_payload_length (out_payload_length),
    .out_status         (out_status),
    .out_received_crc   (out_received_crc),
    .out_computed_crc   (out_computed_crc)
  );

endmodule
